FILE: design/rrts_pkg.sv
// Package for the round-robin time-slice scheduler: field widths, reset values,
// event and register codes, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rrts_pkg;

    // Default number of task slots (table and ring depth).
    localparam int TASK_COUNT_DEF = 16;

    localparam int TASK_ID_W  = 4;
    localparam int PRIO_W     = 8;
    localparam int TICK_W     = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    localparam logic [TASK_ID_W-1:0] IDLE_TASK_RST = 4'd15;
    localparam logic [PRIO_W-1:0]    MAIN_PRIO_RST = 8'd31;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_BLOCK = 2'd1,
        KIND_WAKE  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IDLE_TASK     = 1'b0,
        CFG_MAIN_PRIORITY = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic exec;      // apply the scheduling update
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } t_dp_sts;

    // Reduce a task id modulo the slot count by repeated subtraction. The id is
    // four bits wide and the count at least two, so seven steps suffice.
    function automatic logic [TASK_ID_W-1:0] id_mod(input logic [TASK_ID_W-1:0] v,
                                                     input int unsigned n);
        logic [TASK_ID_W-1:0] r;
        r = v;
        for (int k = 0; k < 8; k++) begin
            if ((n < 16) && (32'(r) >= n)) begin
                r = r - TASK_ID_W'(n);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/rrts_ctrl.sv
// Controller of the round-robin time-slice scheduler: the sequencing state
// machine that drives the datapath. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // The next request may enter in the same cycle the result leaves.
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    in_ready       = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = in_ready & i_rst_n;

endmodule

FILE: design/rrts_dpath.sv
// Datapath of the round-robin time-slice scheduler: ready ring, per-task tables,
// ready bits, tick count, idle register and output register. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_dpath
    import rrts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [TASK_ID_W-1:0]  i_task_req,
    input  logic [PRIO_W-1:0]     i_priority_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [TASK_ID_W-1:0]  o_running_task,
    output logic                  o_switched,
    output logic [TICK_W-1:0]     o_global_ticks,
    output logic [TICK_W-1:0]     o_running_elapsed,
    output logic                  o_fault
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int CNT_W = $clog2(TASK_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    // Memories.
    logic [TASK_ID_W-1:0] ring_mem    [TASK_COUNT];
    logic [TICK_W-1:0]    elapsed_mem [TASK_COUNT];
    logic [PRIO_W-1:0]    remain_mem  [TASK_COUNT];
    logic [PRIO_W-1:0]    slice_mem   [TASK_COUNT];

    // Per-entry written marks for the tables with a defined reset value.
    logic [TASK_COUNT-1:0] r_el_vld;
    logic [TASK_COUNT-1:0] r_rem_vld;
    logic [TASK_COUNT-1:0] r_sl_vld;

    // Scheduler state.
    logic [TASK_ID_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [TASK_COUNT-1:0] r_ready, n_ready;
    logic [TICK_W-1:0]     r_total, n_total;
    logic [TASK_ID_W-1:0]  r_idle, n_idle;

    // Captured request and per-request flags.
    t_kind                r_kind;
    logic [TASK_ID_W-1:0] r_req;
    logic [PRIO_W-1:0]    r_prio;
    logic                 r_switched, n_switched;
    logic                 r_fault, n_fault;

    // Registered read data.
    logic [TASK_ID_W-1:0] r_rd_ring;
    logic [TICK_W-1:0]    r_rd_el;
    logic [PRIO_W-1:0]    r_rd_rem;
    logic [PRIO_W-1:0]    r_rd_sl;
    logic                 r_rd_el_vld;
    logic                 r_rd_rem_vld;
    logic                 r_rd_sl_vld;
    logic                 r_rd_is0;

    // Output register.
    logic                 r_out_valid;
    logic [TASK_ID_W-1:0] r_out_task;
    logic                 r_out_sw;
    logic [TICK_W-1:0]    r_out_total;
    logic [TICK_W-1:0]    r_out_el;
    logic                 r_out_fault;

    // Write ports.
    logic                 ring_we;
    logic [IDX_W-1:0]     ring_waddr;
    logic [TASK_ID_W-1:0] ring_wdata;
    logic                 el_we;
    logic [TICK_W-1:0]    el_wdata;
    logic                 rem_we;
    logic [IDX_W-1:0]     rem_waddr;
    logic [PRIO_W-1:0]    rem_wdata;
    logic                 sl_we;

    logic [IDX_W-1:0]     cur_idx;
    logic [IDX_W-1:0]     req_idx;
    logic [IDX_W-1:0]     head_idx_ring;
    logic [IDX_W-1:0]     head_inc;
    logic [IDX_W-1:0]     head_dec;
    logic [IDX_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [TICK_W-1:0]    rd_el;
    logic [PRIO_W-1:0]    rd_rem;
    logic [PRIO_W-1:0]    rd_sl;
    logic [PRIO_W-1:0]    rst_prio;
    logic                 wake_bad;

    assign cur_idx       = IDX_W'(r_cur);
    assign req_idx       = IDX_W'(r_req);
    assign head_idx_ring = IDX_W'(r_rd_ring);
    assign head_inc      = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec      = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_sum      = (IDX_W+1)'(r_head) + (IDX_W+1)'(r_count);
    assign tail_idx      = (tail_sum >= (IDX_W+1)'(TASK_COUNT))
                           ? IDX_W'(tail_sum - (IDX_W+1)'(TASK_COUNT))
                           : IDX_W'(tail_sum);

    // Entries never written read as their reset value.
    assign rst_prio = r_rd_is0 ? MAIN_PRIO_RST : '0;
    assign rd_el    = r_rd_el_vld  ? r_rd_el  : '0;
    assign rd_rem   = r_rd_rem_vld ? r_rd_rem : rst_prio;
    assign rd_sl    = r_rd_sl_vld  ? r_rd_sl  : rst_prio;

    assign wake_bad = (32'(r_req) >= 32'(TASK_COUNT)) || r_ready[req_idx] || (r_req == r_cur);

    // Configuration. Main priority only seeds task zero's slice at reset, where it
    // holds its reset value; a later write leaves the tables unchanged.
    always_comb begin
        n_idle = r_idle;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_IDLE_TASK:     n_idle = i_cfg_wdata[TASK_ID_W-1:0];
                CFG_MAIN_PRIORITY: n_idle = r_idle;
                default:           n_idle = r_idle;
            endcase
        end
    end

    // Scheduling update.
    always_comb begin
        n_cur      = r_cur;
        n_head     = r_head;
        n_count    = r_count;
        n_ready    = r_ready;
        n_total    = r_total;
        n_switched = r_switched;
        n_fault    = r_fault;
        ring_we    = 1'b0;
        ring_waddr = tail_idx;
        ring_wdata = r_cur;
        el_we      = 1'b0;
        el_wdata   = rd_el + 32'd1;
        rem_we     = 1'b0;
        rem_waddr  = cur_idx;
        rem_wdata  = rd_rem - 8'd1;
        sl_we      = 1'b0;
        if (i_cmd.exec) begin
            n_switched = 1'b0;
            n_fault    = 1'b0;
            case (r_kind)
                KIND_TICK: begin
                    el_we   = 1'b1;
                    n_total = r_total + 32'd1;
                    rem_we  = 1'b1;
                    if (rd_rem == '0) begin
                        // Slice used up: reload and, if tasks are ready, requeue at the tail and take the head.
                        rem_wdata  = rd_sl;
                        ring_we    = 1'b1;
                        n_head     = head_inc;
                        n_switched = 1'b1;
                        if (r_count != '0) begin
                            n_ready[cur_idx]       = 1'b1;
                            n_ready[head_idx_ring] = 1'b0;
                            n_cur                  = r_rd_ring;
                        end
                    end
                end
                KIND_BLOCK: begin
                    n_switched = 1'b1;
                    if (r_count == '0) begin
                        n_cur = id_mod(r_idle, TASK_COUNT);
                    end else begin
                        n_cur                  = r_rd_ring;
                        n_head                 = head_inc;
                        n_count                = r_count - 1'b1;
                        n_ready[head_idx_ring] = 1'b0;
                    end
                end
                KIND_WAKE: begin
                    if (wake_bad) begin
                        n_fault = 1'b1;
                    end else begin
                        sl_we            = 1'b1;
                        rem_we           = 1'b1;
                        rem_waddr        = req_idx;
                        rem_wdata        = r_prio;
                        ring_we          = 1'b1;
                        ring_waddr       = head_dec;
                        ring_wdata       = r_req;
                        n_head           = head_dec;
                        n_count          = r_count + 1'b1;
                        n_ready[req_idx] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_ready     <= '0;
            r_total     <= '0;
            r_idle      <= IDLE_TASK_RST;
            r_el_vld    <= '0;
            r_rem_vld   <= '0;
            r_sl_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_head  <= n_head;
            r_count <= n_count;
            r_ready <= n_ready;
            r_total <= n_total;
            r_idle  <= n_idle;
            if (el_we) begin
                r_el_vld[cur_idx] <= 1'b1;
            end
            if (rem_we) begin
                r_rem_vld[rem_waddr] <= 1'b1;
            end
            if (sl_we) begin
                r_sl_vld[req_idx] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured request, flags and output payload.
    always_ff @(posedge i_clk) begin
        r_switched <= n_switched;
        r_fault    <= n_fault;
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_req  <= i_task_req;
            r_prio <= i_priority_req;
        end
        if (i_cmd.load_out) begin
            r_out_task  <= r_cur;
            r_out_sw    <= r_switched;
            r_out_total <= r_total;
            r_out_el    <= rd_el;
            r_out_fault <= r_fault;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (el_we) begin
            elapsed_mem[cur_idx] <= el_wdata;
        end
        if (rem_we) begin
            remain_mem[rem_waddr] <= rem_wdata;
        end
        if (sl_we) begin
            slice_mem[req_idx] <= r_prio;
        end
        r_rd_ring    <= ring_mem[r_head];
        r_rd_el      <= elapsed_mem[cur_idx];
        r_rd_rem     <= remain_mem[cur_idx];
        r_rd_sl      <= slice_mem[cur_idx];
        r_rd_el_vld  <= r_el_vld[cur_idx];
        r_rd_rem_vld <= r_rem_vld[cur_idx];
        r_rd_sl_vld  <= r_sl_vld[cur_idx];
        r_rd_is0     <= (cur_idx == '0);
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_running_task   = r_out_task;
    assign o_switched       = r_out_sw;
    assign o_global_ticks   = r_out_total;
    assign o_running_elapsed = r_out_el;
    assign o_fault          = r_out_fault;

endmodule

FILE: design/round_robin_time_slice_scheduler.sv
// Top level of the round-robin time-slice scheduler: stream ports and the
// controller/datapath pair. Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
`timescale 1ns / 1ps

// How to use this block
// Requests arrive on the slave stream. Each request is one scheduler event:
// a timer tick, a block of the running task, or a wake of a task with a new
// slice length. The event kind travels in s_axis_tuser, the task id and slice
// in s_axis_tdata. Every request yields exactly one result on the master
// stream: the task running afterwards, whether a dispatch happened, the global
// tick count, the running task's elapsed ticks and a fault flag for an ignored
// wake.
// Each request passes through the table read-modify-write in order: an
// update of the running task's entries and the ready ring from registered
// reads, a read-back of the elapsed count of the task dispatched, and a load
// of the output register. No new request is taken before that load.
// If the receiver stalls, the result waits in the output register; a finished
// request then holds and no new request is taken until the result leaves.
// A new request may be accepted in the same cycle as a result is taken.
// Reset (synchronous, active low) makes task zero the running task with a slice
// of 31 ticks, empties the ready ring and clears all counters; the tables need no
// clearing pass, and s_axis_tready is low while reset is held.
// Configuration writes (idle task id, main priority) are taken at any clock
// edge with i_cfg_we high and must only be issued while the block is idle.

module round_robin_time_slice_scheduler
    import rrts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] task_req, [11:4] priority_req, [15:12] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]      s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] running_task, [4] switched, [36:5] global_ticks,
    // [68:37] running_elapsed, [69] fault, [71:70] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [TASK_ID_W-1:0] running_task;
    logic                 switched;
    logic [TICK_W-1:0]    global_ticks;
    logic [TICK_W-1:0]    running_elapsed;
    logic                 fault;

    // The sequencer decides when a request is taken and when the tables update.
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // The datapath holds the ring, the per-task tables and the output register.
    rrts_dpath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_kind            (s_axis_tuser),
        .i_task_req        (s_axis_tdata[3:0]),
        .i_priority_req    (s_axis_tdata[11:4]),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_running_task    (running_task),
        .o_switched        (switched),
        .o_global_ticks    (global_ticks),
        .o_running_elapsed (running_elapsed),
        .o_fault           (fault)
    );

    assign m_axis_tdata = {2'b00, fault, running_elapsed, global_ticks, switched, running_task};

endmodule

FILE: design/rrts_checker.sv
// Port-level checker for the round-robin time-slice scheduler and the bind that
// attaches it to the top level. Depends on rrts_pkg and the top level.
`timescale 1ns / 1ps

module rrts_checker
    import rrts_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Only one request is in flight: the port closes right after a request.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request accepted while another was in progress");

    // Each rise of the result valid must trace back to an accepted request.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc, 4))
        else $error("result appeared without a matching request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
